@@ rtl/mtfl_pkg.sv @@
// Shared definitions for the move-to-front list core.
// Holds opcodes, status codes, the sequencer state type and the default depth.
// Used by rtl/move_to_front_list_core.sv and the testbench; depends on nothing.
package mtfl_pkg;

   localparam int DEFAULT_DEPTH = 16;

   localparam logic [1:0] OP_APPEND = 2'd0;
   localparam logic [1:0] OP_MOVE   = 2'd1;
   localparam logic [1:0] OP_READ   = 2'd2;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   localparam logic [2:0] ST_DONE   = 3'd0;
   localparam logic [2:0] ST_FIRST  = 3'd1;
   localparam logic [2:0] ST_ABSENT = 3'd2;
   localparam logic [2:0] ST_FULL   = 3'd3;
   localparam logic [2:0] ST_RANGE  = 3'd4;

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_SEARCH = 4'b0010,
      S_SHIFT  = 4'b0100,
      S_READ   = 4'b1000
   } state_type;

endpackage

@@ rtl/move_to_front_list_core.sv @@
// Move-to-front list core: an ordered list of signed words in a local memory.
// Sequencer with one memory write port, one read port and one 32-bit comparator.
// Depends on rtl/mtfl_pkg.sv.
//
// Usage:
//   Command channel: a transfer happens at a rising edge with start high and
//   busy low. req_opcode selects append (0), move to front (1) or read (2);
//   opcode 3 does nothing and reports done.
//   Result channel: rsp_strobe is high for exactly one cycle with the status,
//   found position, list length and read data. The receiver cannot stall;
//   every command gives exactly one result.
//   Append, the unused opcode and a read out of range answer from idle; a
//   read in range passes through S_READ, and a move through S_SEARCH and,
//   when the value is found past the head, S_SHIFT.
//   The move time is set by the single read port: the search reads one
//   entry per cycle, comparing it in the cycle after its read, then the
//   shift moves one entry per cycle, and the head is written last.
//   busy is high from a move or in-range read transfer until its strobe
//   cycle; other commands leave it low. One command is in flight at a time.
//   Reset: clears the entry count and the sequencer. The memory contents are
//   not cleared; only entries below the count are ever used.
module move_to_front_list_core #(
   parameter int DEPTH = mtfl_pkg::DEFAULT_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_opcode,
   input  logic signed [31:0] req_item_value,
   input  logic [3:0]         req_read_index,
   output logic               rsp_strobe,
   output logic [2:0]         rsp_status,
   output logic [3:0]         rsp_found_position,
   output logic [4:0]         rsp_list_length,
   output logic signed [31:0] rsp_read_data
);

   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW   = $clog2(DEPTH + 1);
   localparam int CMPW = (CW > 4) ? CW : 4;

   // List storage: one write port, one registered read port.
   logic [31:0]       mem [DEPTH];
   logic [31:0]       rdata_ff;
   logic [AW-1:0]     rd_addr;
   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic [31:0]       wr_data;

   // Sequencer and working registers.
   mtfl_pkg::state_type state_ff, state_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [31:0]       val_ff, val_in;
   logic [CW-1:0]     ptr_ff, ptr_in;     // next entry to read in search
   logic              pend_ff, pend_in;   // rdata_ff holds entry pos_ff
   logic [AW-1:0]     pos_ff, pos_in;     // entry under compare; match position
   logic [AW-1:0]     wptr_ff, wptr_in;   // next entry to write in shift

   // Result registers.
   logic              strobe_ff;
   logic [2:0]        status_ff;
   logic [3:0]        fpos_ff;
   logic [4:0]        len_ff;
   logic signed [31:0] data_ff;

   logic              emit;
   logic [2:0]        emit_status;
   logic [3:0]        emit_pos;
   logic [31:0]       emit_data;

   logic              accept;
   logic              match;

   assign accept = start && (state_ff == mtfl_pkg::S_IDLE);
   assign match  = pend_ff && (rdata_ff == val_ff);

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      val_in      = val_ff;
      ptr_in      = ptr_ff;
      pend_in     = pend_ff;
      pos_in      = pos_ff;
      wptr_in     = wptr_ff;
      rd_addr     = '0;
      wr_en       = 1'b0;
      wr_addr     = '0;
      wr_data     = '0;
      emit        = 1'b0;
      emit_status = mtfl_pkg::ST_DONE;
      emit_pos    = '0;
      emit_data   = '0;

      case (state_ff)
         mtfl_pkg::S_IDLE: begin
            if (accept) begin
               case (req_opcode)
                  mtfl_pkg::OP_APPEND: begin
                     emit = 1'b1;
                     if (count_ff >= CW'(DEPTH)) begin
                        emit_status = mtfl_pkg::ST_FULL;
                     end else begin
                        // Write the tail and grow the list.
                        wr_en    = 1'b1;
                        wr_addr  = count_ff[AW-1:0];
                        wr_data  = req_item_value;
                        count_in = count_ff + CW'(1);
                     end
                  end
                  mtfl_pkg::OP_MOVE: begin
                     // Start the search at the head.
                     val_in   = req_item_value;
                     ptr_in   = '0;
                     pend_in  = 1'b0;
                     state_in = mtfl_pkg::S_SEARCH;
                  end
                  mtfl_pkg::OP_READ: begin
                     if (CMPW'(req_read_index) < CMPW'(count_ff)) begin
                        rd_addr  = AW'(req_read_index);
                        state_in = mtfl_pkg::S_READ;
                     end else begin
                        emit        = 1'b1;
                        emit_status = mtfl_pkg::ST_RANGE;
                     end
                  end
                  default: begin
                     emit = 1'b1;
                  end
               endcase
            end
         end

         mtfl_pkg::S_SEARCH: begin
            if (match) begin
               if (pos_ff == '0) begin
                  emit        = 1'b1;
                  emit_status = mtfl_pkg::ST_FIRST;
                  state_in    = mtfl_pkg::S_IDLE;
               end else begin
                  // Fetch the entry just ahead of the match to start the shift.
                  rd_addr  = pos_ff - AW'(1);
                  wptr_in  = pos_ff;
                  state_in = mtfl_pkg::S_SHIFT;
               end
            end else if (ptr_ff < count_ff) begin
               // Read the next entry; compare it next cycle.
               rd_addr = ptr_ff[AW-1:0];
               pend_in = 1'b1;
               pos_in  = ptr_ff[AW-1:0];
               ptr_in  = ptr_ff + CW'(1);
            end else begin
               emit        = 1'b1;
               emit_status = mtfl_pkg::ST_ABSENT;
               state_in    = mtfl_pkg::S_IDLE;
            end
         end

         mtfl_pkg::S_SHIFT: begin
            wr_en = 1'b1;
            if (wptr_ff != '0) begin
               // Move one entry down and read the one before it.
               wr_addr = wptr_ff;
               wr_data = rdata_ff;
               rd_addr = wptr_ff - AW'(2);
               wptr_in = wptr_ff - AW'(1);
            end else begin
               // Drop the value at the head and finish.
               wr_addr     = '0;
               wr_data     = val_ff;
               emit        = 1'b1;
               emit_status = mtfl_pkg::ST_DONE;
               emit_pos    = 4'(pos_ff);
               state_in    = mtfl_pkg::S_IDLE;
            end
         end

         mtfl_pkg::S_READ: begin
            emit      = 1'b1;
            emit_data = rdata_ff;
            state_in  = mtfl_pkg::S_IDLE;
         end

         default: begin
            state_in = mtfl_pkg::S_IDLE;
         end
      endcase
   end

   // Storage: no reset, contents are valid only below the count.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rdata_ff <= mem[rd_addr];
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= mtfl_pkg::S_IDLE;
         count_ff  <= '0;
         strobe_ff <= 1'b0;
         pend_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         strobe_ff <= emit;
         pend_ff   <= pend_in;
      end
   end

   // Working and result payload: hold unless updated.
   always_ff @(posedge clock) begin
      val_ff  <= val_in;
      ptr_ff  <= ptr_in;
      pos_ff  <= pos_in;
      wptr_ff <= wptr_in;
      if (emit) begin
         status_ff <= emit_status;
         fpos_ff   <= emit_pos;
         len_ff    <= 5'(count_in);
         data_ff   <= emit_data;
      end
   end

   assign busy               = (state_ff != mtfl_pkg::S_IDLE);
   assign rsp_strobe         = strobe_ff;
   assign rsp_status         = status_ff;
   assign rsp_found_position = fpos_ff;
   assign rsp_list_length    = len_ff;
   assign rsp_read_data      = data_ff;

   // The count never passes the capacity.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("entry count above capacity");

   // A result always comes out with the sequencer back at idle.
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result strobe while busy");

   // The shift write pointer never runs past the match position.
   a_shift_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mtfl_pkg::S_SHIFT) |-> (wptr_ff <= pos_ff))
      else $error("shift pointer beyond match position");

   // Append and the unused opcode answer in the next cycle.
   a_quick_ops: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_opcode == mtfl_pkg::OP_APPEND ||
                          req_opcode == mtfl_pkg::OP_UNUSED)) |=> rsp_strobe)
      else $error("missing one-cycle result");

endmodule

@@ sim/tb_move_to_front_list_core.sv @@
// Self-checking testbench for move_to_front_list_core: directed table, then random commands.
// Expects each result from a local list copy or a typed row; checks it field by field.
// Depends on rtl/mtfl_pkg.sv and rtl/move_to_front_list_core.sv.
`timescale 1ns / 1ps

module tb_move_to_front_list_core;

   localparam int LIST_DEPTH   = mtfl_pkg::DEFAULT_DEPTH;
   localparam int RANDOM_ITEMS = 1925;
   // longest command is a move that hits the tail
   localparam int DRAIN_CYCLES = 2 * LIST_DEPTH + 8;

   typedef struct packed {
      logic [2:0]  status;
      logic [3:0]  position;
      logic [4:0]  length;
      logic [31:0] data;
   } mtf_result_type;

   // one line of the directed table; typed rows carry their result written out
   typedef struct packed {
      logic [1:0]     op;
      logic [31:0]    value;
      logic [3:0]     index;
      bit             typed;
      mtf_result_type want;
   } mtf_row_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [1:0]         req_opcode = mtfl_pkg::OP_APPEND;
   logic signed [31:0] req_item_value = '0;
   logic [3:0]         req_read_index = '0;
   logic               rsp_strobe;
   logic [2:0]         rsp_status;
   logic [3:0]         rsp_found_position;
   logic [4:0]         rsp_list_length;
   logic signed [31:0] rsp_read_data;

   // shadow copy of the list, advanced at every command transfer
   logic [31:0] shadow_list [LIST_DEPTH];
   int          shadow_count = 0;

   mtf_result_type expected_results [$];
   mtf_row_type    directed_rows [$];
   mtf_result_type oldest;
   int             mismatch_count = 0;
   int             burst_left = 0;
   int             op_seen [4] = '{default: 0};
   int             status_seen [8] = '{default: 0};

   move_to_front_list_core #(
      .DEPTH(LIST_DEPTH)
   ) u_top (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_opcode         (req_opcode),
      .req_item_value     (req_item_value),
      .req_read_index     (req_read_index),
      .rsp_strobe         (rsp_strobe),
      .rsp_status         (rsp_status),
      .rsp_found_position (rsp_found_position),
      .rsp_list_length    (rsp_list_length),
      .rsp_read_data      (rsp_read_data)
   );

   // 10 ns period
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Apply one command to the shadow list and return the result it must give.
   function automatic mtf_result_type predict_command(input logic [1:0] op,
         input logic [31:0] value, input logic [3:0] index);
      mtf_result_type r;
      int             hit;
      r = '0;
      r.status = mtfl_pkg::ST_DONE;
      case (op)
         mtfl_pkg::OP_APPEND: begin
            if (shadow_count >= LIST_DEPTH) begin
               r.status = mtfl_pkg::ST_FULL;
            end else begin
               shadow_list[shadow_count] = value;
               shadow_count++;
            end
         end
         mtfl_pkg::OP_MOVE: begin
            // scan from the tail so the match nearest the head wins
            hit = -1;
            for (int k = shadow_count - 1; k >= 0; k--)
               if (shadow_list[k] == value) hit = k;
            if (hit < 0) begin
               r.status = mtfl_pkg::ST_ABSENT;
            end else if (hit == 0) begin
               r.status = mtfl_pkg::ST_FIRST;
            end else begin
               for (int j = hit; j > 0; j--) shadow_list[j] = shadow_list[j - 1];
               shadow_list[0] = value;
               r.position = hit[3:0];
            end
         end
         mtfl_pkg::OP_READ: begin
            if (index < shadow_count) r.data = shadow_list[index];
            else r.status = mtfl_pkg::ST_RANGE;
         end
         default: ;
      endcase
      r.length = shadow_count[4:0];
      return r;
   endfunction

   task automatic add_row(input logic [1:0] op, input logic [31:0] value,
         input logic [3:0] index, input bit typed, input logic [2:0] status,
         input logic [3:0] position, input logic [4:0] length);
      mtf_row_type row;
      row.op = op;
      row.value = value;
      row.index = index;
      row.typed = typed;
      row.want = '{status: status, position: position, length: length, data: '0};
      directed_rows.push_back(row);
   endtask

   // Drive one command from a falling edge, hold it until the transfer, queue the
   // expected result, then pace the sender in bursts, most of them separated by idle gaps.
   task automatic send_command(input mtf_row_type row);
      mtf_result_type predicted;
      int             gap;
      req_opcode     <= row.op;
      req_item_value <= row.value;
      req_read_index <= row.index;
      start          <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      // transfer at this edge: advance the shadow list now
      predicted = predict_command(row.op, row.value, row.index);
      expected_results.push_back(row.typed ? row.want : predicted);
      op_seen[row.op]++;
      @(negedge clock);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         // about a quarter of the bursts follow straight on with no gap
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
         if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
   endtask

   task automatic check_field(input string field, input logic [31:0] want,
         input logic [31:0] got);
      if (got !== want) begin
         mismatch_count++;
         if (mismatch_count <= 40)
            $display("%0t: %s expected %0h, got %0h", $time, field, want, got);
      end
   endtask

   // Results cannot be held off: take every strobe and match it to the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         status_seen[rsp_status]++;
         if (expected_results.size() == 0) begin
            mismatch_count++;
            $display("%0t: result with none expected, expected nothing, got status %0d",
                     $time, rsp_status);
         end else begin
            oldest = expected_results.pop_front();
            check_field("status", 32'(oldest.status), 32'(rsp_status));
            check_field("found_position", 32'(oldest.position), 32'(rsp_found_position));
            check_field("list_length", 32'(oldest.length), 32'(rsp_list_length));
            check_field("read_data", oldest.data, rsp_read_data);
         end
      end
   end

   initial begin : stimulus
      mtf_row_type row;
      logic [31:0] fill_value;
      int          pick;

      // Directed table. Start on the empty list: read past the end, move with
      // nothing to find, and the unused opcode with every field bit set.
      add_row(mtfl_pkg::OP_READ, 32'h0, 4'd0, 1'b1, mtfl_pkg::ST_RANGE, 4'd0, 5'd0);
      add_row(mtfl_pkg::OP_MOVE, 32'h0000_0005, 4'd0, 1'b1, mtfl_pkg::ST_ABSENT,
              4'd0, 5'd0);
      add_row(mtfl_pkg::OP_UNUSED, 32'hFFFF_FFFF, 4'hF, 1'b1, mtfl_pkg::ST_DONE,
              4'd0, 5'd0);
      // Fill the list: both signed extremes, zero, minus one, a duplicate of the
      // maximum at position 4, then distinct values up to the tail.
      for (int i = 0; i < LIST_DEPTH; i++) begin
         case (i)
            0:       fill_value = 32'h8000_0000;
            1, 4:    fill_value = 32'h7FFF_FFFF;
            2:       fill_value = 32'h0000_0000;
            3:       fill_value = 32'hFFFF_FFFF;
            default: fill_value = 32'h0F0F_0000 + i * 32'h0001_0101;
         endcase
         add_row(mtfl_pkg::OP_APPEND, fill_value, 4'(i), 1'b1, mtfl_pkg::ST_DONE,
                 4'd0, 5'(i + 1));
      end
      // append to a full list is refused
      add_row(mtfl_pkg::OP_APPEND, 32'h2468_ACE0, 4'd0, 1'b1, mtfl_pkg::ST_FULL,
              4'd0, 5'(LIST_DEPTH));
      // head already first; duplicate maximum takes the match nearest the head
      add_row(mtfl_pkg::OP_MOVE, 32'h8000_0000, 4'd0, 1'b1, mtfl_pkg::ST_FIRST,
              4'd0, 5'(LIST_DEPTH));
      add_row(mtfl_pkg::OP_MOVE, 32'h7FFF_FFFF, 4'd0, 1'b1, mtfl_pkg::ST_DONE,
              4'd1, 5'(LIST_DEPTH));
      // move the tail entry: longest shift
      add_row(mtfl_pkg::OP_MOVE, 32'h0F0F_0000 + 15 * 32'h0001_0101, 4'd0, 1'b1,
              mtfl_pkg::ST_DONE, 4'(LIST_DEPTH - 1), 5'(LIST_DEPTH));
      // read the last slot against the predictor, then miss on an absent value
      add_row(mtfl_pkg::OP_READ, 32'h0, 4'hF, 1'b0, mtfl_pkg::ST_DONE, 4'd0, 5'd0);
      add_row(mtfl_pkg::OP_MOVE, 32'h1357_9BDF, 4'd0, 1'b1, mtfl_pkg::ST_ABSENT,
              4'd0, 5'(LIST_DEPTH));

      // hold reset, then release it on a falling edge
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      while (directed_rows.size() != 0) begin
         row = directed_rows.pop_front();
         send_command(row);
      end

      // Random part. The list stays full from here on, so weight toward moves
      // of values actually held (hits at every position) and reads, with some
      // refused appends, misses with random values and unused opcodes as noise.
      repeat (RANDOM_ITEMS) begin
         pick = $urandom_range(0, 99);
         if (pick < 10)      row.op = mtfl_pkg::OP_APPEND;
         else if (pick < 55) row.op = mtfl_pkg::OP_MOVE;
         else if (pick < 95) row.op = mtfl_pkg::OP_READ;
         else                row.op = mtfl_pkg::OP_UNUSED;
         row.value = $urandom;
         row.index = 4'($urandom_range(0, 15));
         row.typed = 1'b0;
         row.want = '0;
         if (row.op == mtfl_pkg::OP_MOVE && shadow_count > 0 && $urandom_range(0, 4) != 0)
            row.value = shadow_list[$urandom_range(0, shadow_count - 1)];
         send_command(row);
      end
      start <= 1'b0;

      // drain: wait out every pending result, then longer than the longest command takes
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d commands: %0d append, %0d move, %0d read, %0d unused opcode.",
               op_seen[0] + op_seen[1] + op_seen[2] + op_seen[3],
               op_seen[mtfl_pkg::OP_APPEND], op_seen[mtfl_pkg::OP_MOVE],
               op_seen[mtfl_pkg::OP_READ], op_seen[mtfl_pkg::OP_UNUSED]);
      $display("Results by status done/first/absent/full/range: %0d/%0d/%0d/%0d/%0d.",
               status_seen[mtfl_pkg::ST_DONE], status_seen[mtfl_pkg::ST_FIRST],
               status_seen[mtfl_pkg::ST_ABSENT], status_seen[mtfl_pkg::ST_FULL],
               status_seen[mtfl_pkg::ST_RANGE]);
      if (mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // Watchdog: a correct run needs well under 1 ms.
   initial begin
      #5_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
